/* rtl/baace_pkg.sv */
// ----------------------------------------------------------------------------
// baace_pkg - shared constants for the block average ANSI encoder
// Holds register indexes, default sizes and the fixed byte codes.
// ----------------------------------------------------------------------------
package baace_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_BLOCK = 256;

    // register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

    // colour formats
    localparam logic [1:0] FMT_GREY = 2'd0;
    localparam logic [1:0] FMT_RGB3 = 2'd1;

    // byte codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

endpackage

/* rtl/block_average_ansi_color_encoder.sv */
// ----------------------------------------------------------------------------
// block_average_ansi_color_encoder - box downsampler with ANSI SGR output
// Sums pixels per tile, divides by tile area and emits terminal bytes.
// ----------------------------------------------------------------------------
// Order: a pixel that completes no tile is taken, read, added and written back,
// and its position is stepped; no new pixel is accepted before that ends. A completed
// tile then runs a restoring division per channel in one shared subtract unit,
// a decode step and the byte emission, each decimal value taking an extra step.
// After reset a clearing pass sweeps the whole sum memory and finds the whole
// tile extents before the first pixel; any register write repeats it.
module block_average_ansi_color_encoder
#(
    parameter int MAX_WIDTH = baace_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = baace_pkg::DEF_MAX_BLOCK
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [23:0] color_code, [31:24] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] color_format
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_byte
);
    import baace_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int PW1 = PW + 1;
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int SW = 8 + 2 * BW;          // sum width
    localparam int DW = 2 * BW;              // area width
    localparam int SQW = 5;

    // sequencer codes
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_ADD   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_DEC   = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;
    localparam logic [3:0] ST_ROWE  = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;

    // emit sequence codes
    localparam logic [4:0] E_ESC = 5'd0, E_LB = 5'd1, E_4 = 5'd2, E_8 = 5'd3;
    localparam logic [4:0] E_S1 = 5'd4, E_2 = 5'd5, E_S2 = 5'd6;
    localparam logic [4:0] E_R = 5'd7, E_S3 = 5'd8, E_G = 5'd9, E_S4 = 5'd10;
    localparam logic [4:0] E_B = 5'd11, E_M = 5'd12;
    localparam logic [4:0] E_RESC = 5'd13, E_RLB = 5'd14, E_R0 = 5'd15;
    localparam logic [4:0] E_RM = 5'd16, E_SP = 5'd17;
    localparam logic [4:0] E_XESC = 5'd18, E_XLB = 5'd19, E_X0 = 5'd20;
    localparam logic [4:0] E_XM = 5'd21, E_LF = 5'd22, E_DONE = 5'd23;

    typedef logic [3*SW-1:0] sums_t;

    // clamp a register write
    function automatic logic [PW-1:0] clamp_img(input logic [11:0] v);
        if (v == 12'd0) return PW'(1);
        if (32'(v) > MAX_WIDTH) return PW'(MAX_WIDTH);
        return PW'(v);
    endfunction
    function automatic logic [BW-1:0] clamp_blk(input logic [8:0] v);
        if (v == 9'd0) return BW'(1);
        if (32'(v) > MAX_BLOCK) return BW'(MAX_BLOCK);
        return BW'(v);
    endfunction

    logic [PW-1:0] img_w_reg, img_h_reg;
    logic [BW-1:0] blk_w_reg, blk_h_reg;
    logic [3:0]    state_reg;
    logic [PW-1:0] col_reg, row_reg;
    logic [AW-1:0] bcol_reg;          // block column index
    logic [BW-1:0] cinb_reg, rinb_reg; // position within tile
    logic [PW-1:0] rowsbase_reg;      // first row past whole block rows
    logic [PW-1:0] colsend_reg;       // first col past whole tiles
    logic [AW-1:0] clr_reg;
    logic [23:0]   pix_reg, prev_reg, avg_reg;
    logic          tile_reg, rowend_reg, rowin_reg, colin_reg;
    sums_t         mem [MAX_WIDTH];
    sums_t         rd_reg;
    logic [SW-1:0] rem_reg, quo_reg;
    logic [1:0]    ch_reg;
    logic [SQW-1:0] bit_reg;
    logic [DW-1:0] area_reg;
    logic [4:0]    eseq_reg;
    logic [1:0]    dig_reg;
    logic [7:0]    obyte_reg;
    logic          olast_reg, ovalid_reg;
    logic          xres_reg;
    // decimal digits
    logic [3:0]    dh, dt, du;
    logic [7:0]    dval;
    logic [7:0]    drem, dunit;
    logic [14:0]   dprod;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;

    // decode the incoming colour
    logic [23:0] dec_pix;
    logic [7:0]  g4;
    always_comb
    begin
        g4 = {s_axis_tdata[3:0], s_axis_tdata[3:0]};
        case (s_axis_tuser)
            FMT_GREY: dec_pix = {g4, g4, g4};
            FMT_RGB3: dec_pix = {s_axis_tdata[11:8], s_axis_tdata[11:8],
                                 s_axis_tdata[7:4], s_axis_tdata[7:4],
                                 s_axis_tdata[3:0], s_axis_tdata[3:0]};
            default:  dec_pix = s_axis_tdata[23:0];
        endcase
    end

    // split the current component into decimal digits
    always_comb
    begin
        case (ch_reg)
            2'd0:    dval = avg_reg[23:16];
            2'd1:    dval = avg_reg[15:8];
            default: dval = avg_reg[7:0];
        endcase
        dh = (dval >= 8'd200) ? 4'd2 : ((dval >= 8'd100) ? 4'd1 : 4'd0);
        drem = dval - ((dval >= 8'd200) ? 8'd200 : ((dval >= 8'd100) ? 8'd100 : 8'd0));
        // tens by reciprocal multiplication, exact below 100
        dprod = 15'(drem) * 15'd205;
        dt = dprod[14:11];
        dunit = drem - {1'b0, dt, 3'b000} - {3'b000, dt, 1'b0};
        du = dunit[3:0];
    end

    logic [7:0] ebyte;
    always_comb
    begin
        case (eseq_reg)
            E_ESC, E_RESC, E_XESC: ebyte = CH_ESC;
            E_LB, E_RLB, E_XLB:    ebyte = CH_LBRK;
            E_4:                   ebyte = CH_FOUR;
            E_8:                   ebyte = CH_EIGHT;
            E_S1, E_S2, E_S3, E_S4: ebyte = CH_SEMI;
            E_2:                   ebyte = CH_TWO;
            E_R0, E_X0:            ebyte = CH_ZERO;
            E_M, E_RM, E_XM:       ebyte = CH_M;
            E_SP:                  ebyte = CH_SPACE;
            E_LF:                  ebyte = CH_LF;
            E_R, E_G, E_B:
            begin
                case (dig_reg)
                    2'd0:    ebyte = CH_ZERO + {4'd0, dh};
                    2'd1:    ebyte = CH_ZERO + {4'd0, dt};
                    default: ebyte = CH_ZERO + {4'd0, du};
                endcase
            end
            default:               ebyte = CH_SPACE;
        endcase
    end

    // next emit step after the current byte
    logic [4:0] enext;
    logic [1:0] dnext, dfirst;
    logic       elast;
    always_comb
    begin
        dnext = dig_reg;
        enext = eseq_reg + 5'd1;
        dfirst = (dval >= 8'd100) ? 2'd0 : ((dval >= 8'd10) ? 2'd1 : 2'd2);
        if ((eseq_reg == E_R || eseq_reg == E_G || eseq_reg == E_B) && dig_reg != 2'd2)
        begin
            enext = eseq_reg;
            dnext = dig_reg + 2'd1;
        end
        else if (eseq_reg == E_M)
            enext = E_SP;
        else if (eseq_reg == E_SP)
            enext = rowend_reg ? (xres_reg ? E_XESC : E_LF) : E_DONE;
        else if (eseq_reg == E_LF)
            enext = E_DONE;
        elast = (enext == E_DONE);
    end

    // load the output register when a byte is produced
    logic is_dig, emit_load;
    always_comb
    begin
        is_dig    = (eseq_reg == E_R || eseq_reg == E_G || eseq_reg == E_B);
        emit_load = (state_reg == ST_EMIT) && (!ovalid_reg || m_axis_tready) &&
                    !(is_dig && dig_reg == 2'd3);
    end

    // sequencer
    logic [SW:0] trial;
    always_comb
    begin
        trial = {rem_reg, quo_reg[SW-1]} - {{(SW+1-DW){1'b0}}, area_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= PW'(1); img_h_reg <= PW'(1);
            blk_w_reg <= BW'(1); blk_h_reg <= BW'(1);
            state_reg <= ST_CLEAR; clr_reg <= '0;
            col_reg <= '0; row_reg <= '0; bcol_reg <= '0;
            cinb_reg <= '0; rinb_reg <= '0; prev_reg <= '0;
            rowsbase_reg <= '0; colsend_reg <= '0;
            ovalid_reg <= 1'b0; eseq_reg <= E_DONE;
        end
        else if (cfg_valid)
        begin
            // write a register and restart the frame
            case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= clamp_img(cfg_data);
                REG_IMAGE_HEIGHT: img_h_reg <= clamp_img(cfg_data);
                REG_BLOCK_WIDTH:  blk_w_reg <= clamp_blk(cfg_data[8:0]);
                default:          blk_h_reg <= clamp_blk(cfg_data[8:0]);
            endcase
            state_reg <= ST_CLEAR; clr_reg <= '0;
            col_reg <= '0; row_reg <= '0; bcol_reg <= '0;
            cinb_reg <= '0; rinb_reg <= '0; prev_reg <= '0;
            rowsbase_reg <= '0; colsend_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (emit_load)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    // sweep the sum memory
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == MAX_WIDTH - 1)
                        state_reg <= ST_IDLE;
                    // step the whole tile limits up by one block while they fit
                    if ({1'b0, colsend_reg} + PW1'(blk_w_reg) <= {1'b0, img_w_reg})
                        colsend_reg <= colsend_reg + PW'(blk_w_reg);
                    if ({1'b0, rowsbase_reg} + PW1'(blk_h_reg) <= {1'b0, img_h_reg})
                        rowsbase_reg <= rowsbase_reg + PW'(blk_h_reg);
                    area_reg     <= DW'(blk_w_reg * blk_h_reg);
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        pix_reg    <= dec_pix;
                        rowin_reg  <= row_reg < rowsbase_reg;
                        colin_reg  <= col_reg < colsend_reg;
                        tile_reg   <= (cinb_reg == blk_w_reg - BW'(1)) &&
                                      (rinb_reg == blk_h_reg - BW'(1));
                        rowend_reg <= (row_reg < rowsbase_reg) &&
                                      (col_reg + PW'(1) >= img_w_reg) &&
                                      (rinb_reg == blk_h_reg - BW'(1));
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    rd_reg    <= mem[bcol_reg];
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (rowin_reg && colin_reg && tile_reg)
                    begin
                        ch_reg  <= 2'd0;
                        bit_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= rd_reg[3*SW-1:2*SW] + SW'(pix_reg[23:16]);
                        rd_reg  <= {rd_reg[3*SW-1:2*SW] + SW'(pix_reg[23:16]),
                                    rd_reg[2*SW-1:SW] + SW'(pix_reg[15:8]),
                                    rd_reg[SW-1:0] + SW'(pix_reg[7:0])};
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        eseq_reg <= rowend_reg ? (prev_reg != 24'd0 ? E_XESC : E_LF) : E_DONE;
                        state_reg <= rowend_reg ? ST_EMIT : ST_NEXT;
                        if (rowend_reg) prev_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (32'(bit_reg) == SW - 1)
                    begin
                        // last step: keep the quotient byte and load the next channel
                        case (ch_reg)
                            2'd0:    avg_reg[23:16] <= {quo_reg[6:0], !trial[SW]};
                            2'd1:    avg_reg[15:8]  <= {quo_reg[6:0], !trial[SW]};
                            default: avg_reg[7:0]   <= {quo_reg[6:0], !trial[SW]};
                        endcase
                        bit_reg <= '0;
                        rem_reg <= '0;
                        ch_reg  <= ch_reg + 2'd1;
                        quo_reg <= (ch_reg == 2'd0) ? rd_reg[2*SW-1:SW] : rd_reg[SW-1:0];
                        if (ch_reg == 2'd2)
                            state_reg <= ST_DEC;
                    end
                    else
                    begin
                        // one restoring step per cycle
                        if (!trial[SW])
                            rem_reg <= trial[SW-1:0];
                        else
                            rem_reg <= {rem_reg[SW-2:0], quo_reg[SW-1]};
                        quo_reg <= {quo_reg[SW-2:0], !trial[SW]};
                        bit_reg <= bit_reg + SQW'(1);
                    end
                end
                ST_DEC:
                begin
                    xres_reg <= avg_reg != 24'd0;
                    if (avg_reg == prev_reg)
                        eseq_reg <= E_SP;
                    else if (avg_reg == 24'd0)
                        eseq_reg <= E_RESC;
                    else
                        eseq_reg <= E_ESC;
                    prev_reg <= rowend_reg ? 24'd0 : avg_reg;
                    ch_reg   <= 2'd0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        if (is_dig)
                        begin
                            if (dig_reg == 2'd3)
                                dig_reg <= dfirst;
                            else
                            begin
                                obyte_reg <= ebyte; olast_reg <= elast;
                                eseq_reg <= enext;
                                if (dig_reg == 2'd2)
                                begin
                                    ch_reg <= ch_reg + 2'd1;
                                    dig_reg <= 2'd3;
                                end
                                else
                                    dig_reg <= dnext;
                            end
                        end
                        else
                        begin
                            obyte_reg <= ebyte; olast_reg <= elast;
                            eseq_reg <= enext;
                            dig_reg <= 2'd3;
                            if (elast) state_reg <= ST_NEXT;
                        end
                    end
                end
                default:
                begin
                    // ST_NEXT: step position (sums are written back in ST_ADD)
                    if (col_reg + PW'(1) >= img_w_reg)
                    begin
                        col_reg <= '0; cinb_reg <= '0; bcol_reg <= '0;
                        if (row_reg + PW'(1) >= img_h_reg)
                        begin
                            row_reg <= '0; rinb_reg <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + PW'(1);
                            rinb_reg <= (rinb_reg == blk_h_reg - BW'(1)) ?
                                        '0 : rinb_reg + BW'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + PW'(1);
                        if (cinb_reg == blk_w_reg - BW'(1))
                        begin
                            cinb_reg <= '0; bcol_reg <= bcol_reg + AW'(1);
                        end
                        else
                            cinb_reg <= cinb_reg + BW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // sum memory write port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_reg] <= '0;
        else if (state_reg == ST_ADD && rowin_reg && colin_reg)
            mem[bcol_reg] <= tile_reg ? '0 :
                {rd_reg[3*SW-1:2*SW] + SW'(pix_reg[23:16]),
                 rd_reg[2*SW-1:SW] + SW'(pix_reg[15:8]),
                 rd_reg[SW-1:0] + SW'(pix_reg[7:0])};
    end

endmodule

/* rtl/baace_checker.sv */
// ----------------------------------------------------------------------------
// baace_checker - port level checks for the block average ANSI encoder
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module baace_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    // hold a stalled output transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_valid)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // a pixel is not taken twice in consecutive cycles
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a byte marked last is a newline or a space
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h0A || m_axis_tdata == 8'h20)
        else $error("last byte not space or newline");

endmodule

bind block_average_ansi_color_encoder baace_checker u_baace_checker
(
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
